// ===== sv/w3dh_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// w3dh_pkg
// Shared types and constants for the weighted 3-D density histogram.
// ----------------------------------------------------------------------------
package w3dh_pkg;

   // default grid size, log2 of cells per axis
   localparam int BINS_X_LOG2_DEF = 4;
   localparam int BINS_Y_LOG2_DEF = 4;
   localparam int BINS_Z_LOG2_DEF = 4;

   localparam int REQ_TDATA_W = 144;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 64;
   localparam int RSP_TUSER_W = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int BIN_NUM_W   = 12;
   localparam int ACC_W       = 48;
   localparam int FRAC_BITS   = 40;

   localparam logic [ACC_W-1:0] ACC_MAX     = '1;
   localparam logic [31:0]      SCALE_RESET = 32'h0100_0000;

   // request kinds
   localparam logic [1:0] REQ_DEPOSIT    = 2'd0;
   localparam logic [1:0] REQ_READ       = 2'd1;
   localparam logic [1:0] REQ_READ_CLEAR = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PERIODIC = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_X    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_Y    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_Z    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_X  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_Y  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_Z  = 3'd6;

   // axis selector
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SUB,
      ST_MUL,
      ST_FOLD,
      ST_RD,
      ST_UPD
   } state_type;

   typedef struct packed {
      logic       capture;
      logic       sub;
      logic       mul;
      logic       fold;
      logic [1:0] axis;
      logic       rd;
      logic       upd;
      logic       clr;
   } cmd_type;

   typedef struct packed {
      logic is_dep;
      logic clr_last;
      logic rsp_free;
   } sts_type;

endpackage
`default_nettype wire

// ===== sv/w3dh_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// w3dh_ctrl
// Sequencer: clearing pass, per-axis sub/mul/fold steps, read-modify-write.
// ----------------------------------------------------------------------------
module w3dh_ctrl (
   input  wire                logic clock,
   input  wire                logic reset,
   input  wire                logic req_tvalid,
   output logic               req_tready,
   input  wire  w3dh_pkg::sts_type  sts,
   output w3dh_pkg::cmd_type  cmd
);

   w3dh_pkg::state_type state_ff, state_in;
   logic [1:0]          axis_ff, axis_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= w3dh_pkg::ST_CLEAR;
         axis_ff  <= w3dh_pkg::AXIS_X;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      unique case (state_ff)
         w3dh_pkg::ST_CLEAR: begin
            if (sts.clr_last) state_in = w3dh_pkg::ST_IDLE;
         end
         w3dh_pkg::ST_IDLE: begin
            axis_in = w3dh_pkg::AXIS_X;
            if (req_tvalid) state_in = w3dh_pkg::ST_SUB;
         end
         w3dh_pkg::ST_SUB: begin
            state_in = sts.is_dep ? w3dh_pkg::ST_MUL : w3dh_pkg::ST_RD;
         end
         w3dh_pkg::ST_MUL: begin
            state_in = w3dh_pkg::ST_FOLD;
         end
         w3dh_pkg::ST_FOLD: begin
            if (axis_ff == w3dh_pkg::AXIS_Z) begin
               axis_in  = w3dh_pkg::AXIS_X;
               state_in = w3dh_pkg::ST_RD;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = w3dh_pkg::ST_SUB;
            end
         end
         w3dh_pkg::ST_RD: begin
            state_in = w3dh_pkg::ST_UPD;
         end
         w3dh_pkg::ST_UPD: begin
            if (sts.rsp_free) state_in = w3dh_pkg::ST_IDLE;
         end
         default: begin
            state_in = w3dh_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      cmd.axis   = axis_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         w3dh_pkg::ST_CLEAR: cmd.clr = 1'b1;
         w3dh_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         w3dh_pkg::ST_SUB:  cmd.sub  = 1'b1;
         w3dh_pkg::ST_MUL:  cmd.mul  = 1'b1;
         w3dh_pkg::ST_FOLD: cmd.fold = 1'b1;
         w3dh_pkg::ST_RD:   cmd.rd   = 1'b1;
         w3dh_pkg::ST_UPD:  cmd.upd  = sts.rsp_free;
         default: cmd = '0;
      endcase
   end

`ifndef SYNTH
   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      axis_ff != 2'd3)
      else $error("axis counter out of range");

   a_last_fold_reads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == w3dh_pkg::ST_FOLD && axis_ff == w3dh_pkg::AXIS_Z)
      |=> (state_ff == w3dh_pkg::ST_RD && axis_ff == w3dh_pkg::AXIS_X))
      else $error("last axis fold did not start the bin read");

   a_upd_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.upd |-> sts.rsp_free)
      else $error("result loaded while output register still full");

   a_clear_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == w3dh_pkg::ST_CLEAR) |-> (!req_tready && !cmd.capture))
      else $error("request accepted during clearing pass");
`endif

endmodule
`default_nettype wire

// ===== sv/w3dh_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// w3dh_dpath
// Registers, shared axis multiplier, bin store and result register.
// ----------------------------------------------------------------------------
module w3dh_dpath #(
   parameter int BINS_X_LOG2 = w3dh_pkg::BINS_X_LOG2_DEF,
   parameter int BINS_Y_LOG2 = w3dh_pkg::BINS_Y_LOG2_DEF,
   parameter int BINS_Z_LOG2 = w3dh_pkg::BINS_Z_LOG2_DEF
) (
   input  wire  logic                                  clock,
   input  wire  logic                                  reset,
   input  wire  w3dh_pkg::cmd_type                     cmd,
   output w3dh_pkg::sts_type                           sts,
   input  wire  logic [w3dh_pkg::REQ_TUSER_W-1:0]      req_tuser,
   input  wire  logic [w3dh_pkg::REQ_TDATA_W-1:0]      req_tdata,
   input  wire  logic                                  csr_valid,
   input  wire  logic [w3dh_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire  logic [w3dh_pkg::CSR_DATA_W-1:0]       csr_data,
   output logic                                        rsp_tvalid,
   input  wire  logic                                  rsp_tready,
   output logic [w3dh_pkg::RSP_TDATA_W-1:0]            rsp_tdata,
   output logic [w3dh_pkg::RSP_TUSER_W-1:0]            rsp_tuser
);

   localparam int AW    = BINS_X_LOG2 + BINS_Y_LOG2 + BINS_Z_LOG2;
   localparam int DEPTH = 1 << AW;
   localparam int FB    = w3dh_pkg::FRAC_BITS;

   // configuration
   logic        periodic_ff;
   logic [31:0] min_x_ff, min_y_ff, min_z_ff;
   logic [31:0] scale_x_ff, scale_y_ff, scale_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         periodic_ff <= 1'b0;
         min_x_ff    <= '0;
         min_y_ff    <= '0;
         min_z_ff    <= '0;
         scale_x_ff  <= w3dh_pkg::SCALE_RESET;
         scale_y_ff  <= w3dh_pkg::SCALE_RESET;
         scale_z_ff  <= w3dh_pkg::SCALE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            w3dh_pkg::CSR_PERIODIC: periodic_ff <= csr_data[0];
            w3dh_pkg::CSR_MIN_X:    min_x_ff    <= csr_data;
            w3dh_pkg::CSR_MIN_Y:    min_y_ff    <= csr_data;
            w3dh_pkg::CSR_MIN_Z:    min_z_ff    <= csr_data;
            w3dh_pkg::CSR_SCALE_X:  scale_x_ff  <= csr_data;
            w3dh_pkg::CSR_SCALE_Y:  scale_y_ff  <= csr_data;
            w3dh_pkg::CSR_SCALE_Z:  scale_z_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // request payload
   logic [1:0]                        type_ff;
   logic [31:0]                       pos_x_ff, pos_y_ff, pos_z_ff, weight_ff;
   logic [w3dh_pkg::BIN_NUM_W-1:0]    rbin_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff   <= req_tuser;
         pos_x_ff  <= req_tdata[31:0];
         pos_y_ff  <= req_tdata[63:32];
         pos_z_ff  <= req_tdata[95:64];
         weight_ff <= req_tdata[127:96];
         rbin_ff   <= req_tdata[139:128];
      end
   end

   // axis select
   logic [31:0] pos_sel, min_sel, scale_sel;

   always_comb begin
      unique case (cmd.axis)
         w3dh_pkg::AXIS_Y: begin
            pos_sel = pos_y_ff; min_sel = min_y_ff; scale_sel = scale_y_ff;
         end
         w3dh_pkg::AXIS_Z: begin
            pos_sel = pos_z_ff; min_sel = min_z_ff; scale_sel = scale_z_ff;
         end
         default: begin
            pos_sel = pos_x_ff; min_sel = min_x_ff; scale_sel = scale_x_ff;
         end
      endcase
   end

   // sub step: magnitude and sign of pos - min
   logic [32:0] diff, mag;
   logic [32:0] mag_ff;
   logic        neg_ff;

   assign diff = {pos_sel[31], pos_sel} - {min_sel[31], min_sel};
   assign mag  = diff[32] ? (33'd0 - diff) : diff;

   // mul step: magnitude below 2^33 times Q8.24 scale, 40 fraction bits
   logic [63:0] prod_full;
   logic [63:0] prod_ff;

   assign prod_full = 64'(mag_ff) * 64'(scale_sel);

   always_ff @(posedge clock) begin
      if (cmd.sub) begin
         mag_ff <= mag;
         neg_ff <= diff[32];
      end
      if (cmd.mul) prod_ff <= prod_full;
   end

   // fold step: wrap or bound check, then take the cell index
   logic [FB-1:0] low, frac;
   logic [7:0]    cell_top;
   logic          axis_ok;

   assign low      = prod_ff[FB-1:0];
   assign frac     = (periodic_ff && neg_ff) ? (FB'(0) - low) : low;
   assign cell_top = frac[FB-1 -: 8];
   assign axis_ok  = periodic_ff ||
                     (!neg_ff && (prod_ff != 64'd0) && (prod_ff[63:FB] == '0));

   logic [BINS_X_LOG2-1:0] ix_ff;
   logic [BINS_Y_LOG2-1:0] iy_ff;
   logic [BINS_Z_LOG2-1:0] iz_ff;
   logic                   ok_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) ok_ff <= 1'b1;
      else if (cmd.fold) ok_ff <= ok_ff & axis_ok;
      if (cmd.fold && cmd.axis == w3dh_pkg::AXIS_X) ix_ff <= cell_top[7 -: BINS_X_LOG2];
      if (cmd.fold && cmd.axis == w3dh_pkg::AXIS_Y) iy_ff <= cell_top[7 -: BINS_Y_LOG2];
      if (cmd.fold && cmd.axis == w3dh_pkg::AXIS_Z) iz_ff <= cell_top[7 -: BINS_Z_LOG2];
   end

   logic is_dep;
   assign is_dep = (type_ff == w3dh_pkg::REQ_DEPOSIT);

   // bin store
   logic [w3dh_pkg::ACC_W-1:0] bin_mem [0:DEPTH-1];
   logic [w3dh_pkg::ACC_W-1:0] mem_q_ff;
   logic [AW-1:0]              rd_addr, addr_ff;
   logic [AW-1:0]              clr_ff, clr_in;
   logic                       wr_en, upd_we;
   logic [AW-1:0]              wr_addr;
   logic [w3dh_pkg::ACC_W-1:0] wr_data, upd_wdata;

   assign rd_addr = is_dep ? (ok_ff ? {ix_ff, iy_ff, iz_ff} : '0) : AW'(rbin_ff);
   assign clr_in  = clr_ff + AW'(1);

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clr) clr_ff <= clr_in;
   end

   assign wr_en   = cmd.clr | (cmd.upd & upd_we);
   assign wr_addr = cmd.clr ? clr_ff : addr_ff;
   assign wr_data = cmd.clr ? '0 : upd_wdata;

   always_ff @(posedge clock) begin
      if (wr_en) bin_mem[wr_addr] <= wr_data;
      if (cmd.rd) begin
         mem_q_ff <= bin_mem[rd_addr];
         addr_ff  <= rd_addr;
      end
   end

   // update: saturating add or read/clear
   logic [w3dh_pkg::ACC_W:0]     sum_wide;
   logic [w3dh_pkg::ACC_W-1:0]   sum_sat, res_val;
   logic [w3dh_pkg::BIN_NUM_W-1:0] res_bin;
   logic                         res_dep;

   assign sum_wide = {1'b0, mem_q_ff} + (w3dh_pkg::ACC_W + 1)'(weight_ff);
   assign sum_sat  = sum_wide[w3dh_pkg::ACC_W] ? w3dh_pkg::ACC_MAX
                                               : sum_wide[w3dh_pkg::ACC_W-1:0];

   always_comb begin
      res_dep   = 1'b0;
      res_bin   = '0;
      res_val   = '0;
      upd_we    = 1'b0;
      upd_wdata = '0;
      unique case (type_ff)
         w3dh_pkg::REQ_DEPOSIT: begin
            if (ok_ff) begin
               res_dep   = 1'b1;
               res_bin   = w3dh_pkg::BIN_NUM_W'(addr_ff);
               res_val   = sum_sat;
               upd_we    = 1'b1;
               upd_wdata = sum_sat;
            end
         end
         w3dh_pkg::REQ_READ: begin
            res_bin = w3dh_pkg::BIN_NUM_W'(addr_ff);
            res_val = mem_q_ff;
         end
         w3dh_pkg::REQ_READ_CLEAR: begin
            res_bin = w3dh_pkg::BIN_NUM_W'(addr_ff);
            res_val = mem_q_ff;
            upd_we  = 1'b1;
         end
         default: ;
      endcase
   end

   // result register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_dep_ff, rsp_sat_ff;
   logic [w3dh_pkg::BIN_NUM_W-1:0] rsp_bin_ff;
   logic [w3dh_pkg::ACC_W-1:0]     rsp_val_ff;

   assign rsp_valid_in = cmd.upd ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.upd) begin
         rsp_dep_ff <= res_dep;
         rsp_bin_ff <= res_bin;
         rsp_val_ff <= res_val;
         rsp_sat_ff <= (res_val == w3dh_pkg::ACC_MAX);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_val_ff, rsp_bin_ff};
   assign rsp_tuser  = {rsp_sat_ff, rsp_dep_ff};

   assign sts.is_dep   = is_dep;
   assign sts.clr_last = (clr_ff == '1);
   assign sts.rsp_free = !rsp_valid_ff || rsp_tready;

endmodule
`default_nettype wire

// ===== sv/weighted_3d_density_histogram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_3d_density_histogram
// Bins weighted particle positions into a 3-D grid of saturating 48-bit sums.
// ----------------------------------------------------------------------------
// After reset the block sweeps the bin store to zero, one entry per cycle,
// over all 2^(BINS_X_LOG2+BINS_Y_LOG2+BINS_Z_LOG2) entries (4096 at the
// defaults), and holds req_tready low during that pass; csr writes are taken
// at any time. Items are handled one at a time. A deposit steps through one
// shared 33x32 multiplier that serves the three axes in turn (subtract,
// multiply, fold per axis), then a registered read and a write of the
// single-port bin store; the result is loaded with the write. Read and
// read-and-clear requests take the subtract step, then the read and the
// update step. The block returns to idle before the next accept. The result
// sits in an output register, so the next item is accepted while it waits;
// a new result stalls only if the previous one has not been taken.
// Bins are numbered with z fastest; bin_number shows the low 12 bits.
// ----------------------------------------------------------------------------
module weighted_3d_density_histogram #(
   parameter int BINS_X_LOG2 = w3dh_pkg::BINS_X_LOG2_DEF,
   parameter int BINS_Y_LOG2 = w3dh_pkg::BINS_Y_LOG2_DEF,
   parameter int BINS_Z_LOG2 = w3dh_pkg::BINS_Z_LOG2_DEF
) (
   input  wire  logic                                  clock,
   input  wire  logic                                  reset,
   input  wire  logic                                  req_tvalid,
   output logic                                        req_tready,
   // pos_x[31:0], pos_y[63:32], pos_z[95:64], weight[127:96], read_bin[139:128]
   input  wire  logic [w3dh_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // req_type[1:0]
   input  wire  logic [w3dh_pkg::REQ_TUSER_W-1:0]      req_tuser,
   output logic                                        rsp_tvalid,
   input  wire  logic                                  rsp_tready,
   // bin_number[11:0], bin_value[59:12]
   output logic [w3dh_pkg::RSP_TDATA_W-1:0]            rsp_tdata,
   // deposited[0], saturated[1]
   output logic [w3dh_pkg::RSP_TUSER_W-1:0]            rsp_tuser,
   input  wire  logic                                  csr_valid,
   output logic                                        csr_ready,
   input  wire  logic [w3dh_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire  logic [w3dh_pkg::CSR_DATA_W-1:0]       csr_data
);

   w3dh_pkg::cmd_type cmd;
   w3dh_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   w3dh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   w3dh_dpath #(
      .BINS_X_LOG2 (BINS_X_LOG2),
      .BINS_Y_LOG2 (BINS_Y_LOG2),
      .BINS_Z_LOG2 (BINS_Z_LOG2)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

// ===== test/tb_weighted_3d_density_histogram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_weighted_3d_density_histogram
// Self-checking bench for the weighted 3-D density histogram. Request beats
// come from a pending queue, and each accepted beat runs through a local bin
// store model. Result beats are compared field by field, in order. The run
// walks through bounded and periodic boxes, zero and full-range scales, a
// long receiver stall and one bin hammered with full-weight deposits.
// ----------------------------------------------------------------------------
module tb_weighted_3d_density_histogram;

   localparam int BX          = w3dh_pkg::BINS_X_LOG2_DEF;
   localparam int BY          = w3dh_pkg::BINS_Y_LOG2_DEF;
   localparam int BZ          = w3dh_pkg::BINS_Z_LOG2_DEF;
   localparam int STORE_DEPTH = 1 << (BX + BY + BZ);

   localparam int WATCHDOG_LIMIT   = 20000;
   localparam int DRAIN_CYCLES     = 40;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int SAT_DEPOSITS     = 100;
   localparam int HOT_BIN_SLOTS    = 16;

   localparam logic [1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] pos_z;
      logic [31:0] weight;
      logic [11:0] read_bin;
   } hist_req_type;

   typedef struct packed {
      logic                       deposited;
      logic [11:0]                bin_number;
      logic [w3dh_pkg::ACC_W-1:0] bin_value;
      logic                       saturated;
   } hist_rsp_type;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [w3dh_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [w3dh_pkg::REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [w3dh_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic [w3dh_pkg::RSP_TUSER_W-1:0] rsp_tuser;
   logic                             csr_valid  = 1'b0;
   logic                             csr_ready;
   logic [w3dh_pkg::CSR_INDEX_W-1:0] csr_index  = '0;
   logic [w3dh_pkg::CSR_DATA_W-1:0]  csr_data   = '0;

   // model state and register copy
   logic [w3dh_pkg::ACC_W-1:0] bin_sums [STORE_DEPTH];
   logic                       cfg_periodic;
   logic [31:0]                cfg_min   [3];
   logic [31:0]                cfg_scale [3];

   hist_req_type pending_req [$];
   hist_rsp_type expected_rsp [$];
   int           hot_bins [$];

   int   error_count   = 0;
   int   stall_cycles  = 0;
   int   send_gap      = 0;
   int   rsp_gap       = 0;
   int   hold_requests = 0;
   int   hold_served   = 0;
   int   hold_left     = 0;
   logic idle_on       = 1'b1;
   logic req_taken     = 1'b0;

   weighted_3d_density_histogram #(
      .BINS_X_LOG2(BX),
      .BINS_Y_LOG2(BY),
      .BINS_Z_LOG2(BZ)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // one axis: fraction with 40 fraction bits, then cell index
   function automatic logic map_axis(input logic [31:0] pos, input logic [31:0] mn,
                                     input logic [31:0] sc, input int lg,
                                     output int cell_idx);
      logic signed [32:0] diff;
      logic [32:0]        mag;
      logic [63:0]        prod;
      logic [39:0]        frac;
      diff = $signed({pos[31], pos}) - $signed({mn[31], mn});
      mag  = diff[32] ? -diff : diff;
      prod = 64'(mag) * 64'(sc);
      cell_idx = 0;
      if (cfg_periodic) begin
         frac = diff[32] ? 40'd0 - prod[39:0] : prod[39:0];
      end else begin
         if (diff[32] || prod == 64'd0 || prod[63:40] != 24'd0)
            return 1'b0;
         frac = prod[39:0];
      end
      cell_idx = int'(frac >> (w3dh_pkg::FRAC_BITS - lg));
      return 1'b1;
   endfunction

   function automatic logic locate_bin(input hist_req_type it, output int bin);
      int   cx, cy, cz;
      logic ok;
      ok  = map_axis(it.pos_x, cfg_min[0], cfg_scale[0], BX, cx);
      ok  = map_axis(it.pos_y, cfg_min[1], cfg_scale[1], BY, cy) && ok;
      ok  = map_axis(it.pos_z, cfg_min[2], cfg_scale[2], BZ, cz) && ok;
      bin = ((cx << (BY + BZ)) | (cy << BZ) | cz) & (STORE_DEPTH - 1);
      return ok;
   endfunction

   function automatic hist_rsp_type predict_result(input hist_req_type it);
      hist_rsp_type r;
      int           bin;
      logic [48:0]  sum;
      r = '0;
      case (it.kind)
         w3dh_pkg::REQ_DEPOSIT: begin
            if (locate_bin(it, bin)) begin
               sum = {1'b0, bin_sums[bin]} + 49'(it.weight);
               if (sum > {1'b0, w3dh_pkg::ACC_MAX})
                  sum = {1'b0, w3dh_pkg::ACC_MAX};
               bin_sums[bin] = sum[w3dh_pkg::ACC_W-1:0];
               r.deposited   = 1'b1;
               r.bin_number  = 12'(bin);
               r.bin_value   = sum[w3dh_pkg::ACC_W-1:0];
            end
         end
         w3dh_pkg::REQ_READ, w3dh_pkg::REQ_READ_CLEAR: begin
            bin          = int'(it.read_bin) & (STORE_DEPTH - 1);
            r.bin_number = 12'(bin);
            r.bin_value  = bin_sums[bin];
            if (it.kind == w3dh_pkg::REQ_READ_CLEAR)
               bin_sums[bin] = '0;
         end
         default: ;
      endcase
      r.saturated = (r.bin_value == w3dh_pkg::ACC_MAX);
      return r;
   endfunction

   function automatic hist_req_type make_request(input logic [1:0] kind,
                                                 input logic [31:0] px, input logic [31:0] py,
                                                 input logic [31:0] pz, input logic [31:0] w,
                                                 input logic [11:0] rb);
      hist_req_type it;
      it.kind     = kind;
      it.pos_x    = px;
      it.pos_y    = py;
      it.pos_z    = pz;
      it.weight   = w;
      it.read_bin = rb;
      return it;
   endfunction

   task automatic check_field(input string name, input logic [w3dh_pkg::ACC_W-1:0] exp_v,
                              input logic [w3dh_pkg::ACC_W-1:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
         error_count++;
      end
   endtask

   task automatic write_csr(input logic [w3dh_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (idx)
         w3dh_pkg::CSR_PERIODIC:
            cfg_periodic = value[0];
         w3dh_pkg::CSR_MIN_X, w3dh_pkg::CSR_MIN_Y, w3dh_pkg::CSR_MIN_Z:
            cfg_min[idx - w3dh_pkg::CSR_MIN_X] = value;
         default:
            cfg_scale[idx - w3dh_pkg::CSR_SCALE_X] = value;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_box(input logic periodic, input logic [31:0] mx, input logic [31:0] my,
                          input logic [31:0] mz, input logic [31:0] sx,
                          input logic [31:0] sy, input logic [31:0] sz);
      write_csr(w3dh_pkg::CSR_PERIODIC, {31'd0, periodic});
      write_csr(w3dh_pkg::CSR_MIN_X, mx);
      write_csr(w3dh_pkg::CSR_MIN_Y, my);
      write_csr(w3dh_pkg::CSR_MIN_Z, mz);
      write_csr(w3dh_pkg::CSR_SCALE_X, sx);
      write_csr(w3dh_pkg::CSR_SCALE_Y, sy);
      write_csr(w3dh_pkg::CSR_SCALE_Z, sz);
   endtask

   task automatic wait_drained();
      while (pending_req.size() != 0 || expected_rsp.size() != 0)
         @(posedge clock);
   endtask

   // mostly in-box deposits, some edge and wild positions, reads of recent bins
   task automatic queue_random_items(input int count);
      hist_req_type it;
      hist_req_type last_dep;
      logic         have_last;
      int           sel;
      int           bin;
      logic [63:0]  span;
      logic [31:0]  offs;
      logic [31:0]  p [3];
      have_last = 1'b0;
      last_dep  = '0;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(0, 99);
         it  = make_request(w3dh_pkg::REQ_DEPOSIT, $urandom, $urandom, $urandom, $urandom,
                            12'($urandom));
         case ($urandom_range(0, 19))
            0, 1:    it.weight = 32'hFFFF_FFFF;
            2:       it.weight = 32'd0;
            default: ;
         endcase
         if (sel < 62) begin
            if (sel < 12 && have_last) begin
               it.pos_x = last_dep.pos_x;
               it.pos_y = last_dep.pos_y;
               it.pos_z = last_dep.pos_z;
            end else begin
               p[0] = it.pos_x;
               p[1] = it.pos_y;
               p[2] = it.pos_z;
               for (int a = 0; a < 3; a++) begin
                  span = 64'hFF_FFFF_FFFF /
                         (cfg_scale[a] == 32'd0 ? 64'd1 : 64'(cfg_scale[a]));
                  if (span > 64'hFFFF_FFFF)
                     span = 64'hFFFF_FFFF;
                  case ($urandom_range(0, 9))
                     0, 1: begin
                        case ($urandom_range(0, 3))
                           0:       offs = 32'd0;
                           1:       offs = 32'd1;
                           2:       offs = span[31:0];
                           default: offs = span[31:0] + 32'd1;
                        endcase
                        p[a] = cfg_min[a] + offs;
                     end
                     8, 9:    ;
                     default: p[a] = cfg_min[a] + $urandom_range(1, span[31:0]);
                  endcase
               end
               it.pos_x = p[0];
               it.pos_y = p[1];
               it.pos_z = p[2];
            end
            last_dep  = it;
            have_last = 1'b1;
            if (locate_bin(it, bin)) begin
               hot_bins.push_back(bin);
               if (hot_bins.size() > HOT_BIN_SLOTS)
                  void'(hot_bins.pop_front());
            end
         end else begin
            if (sel < 80)
               it.kind = w3dh_pkg::REQ_READ;
            else if (sel < 96)
               it.kind = w3dh_pkg::REQ_READ_CLEAR;
            else
               it.kind = REQ_UNUSED;
            if (hot_bins.size() != 0 && $urandom_range(0, 2) != 0)
               it.read_bin = 12'(hot_bins[$urandom_range(0, hot_bins.size() - 1)]);
         end
         pending_req.push_back(it);
      end
   endtask

   // request side: accept and predict
   always @(posedge clock) begin : req_accept
      hist_req_type it;
      req_taken = 1'b0;
      if (!reset && req_tvalid && req_tready) begin
         it = pending_req.pop_front();
         expected_rsp.push_back(predict_result(it));
         req_taken = 1'b1;
      end
   end

   // request side: drive next beat
   always @(negedge clock) begin : req_drive
      if (!req_tvalid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (idle_on && $urandom_range(0, 15) == 0) begin
            send_gap = $urandom_range(0, 14);
            req_tvalid <= 1'b0;
         end else if (pending_req.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {4'd0, pending_req[0].read_bin, pending_req[0].weight,
                           pending_req[0].pos_z, pending_req[0].pos_y, pending_req[0].pos_x};
            req_tuser  <= pending_req[0].kind;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result side: compare against oldest prediction
   always @(posedge clock) begin : rsp_sample
      hist_rsp_type want;
      hist_rsp_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.deposited  = rsp_tuser[0];
         got.saturated  = rsp_tuser[1];
         got.bin_number = rsp_tdata[11:0];
         got.bin_value  = rsp_tdata[59:12];
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual bin %h value %h",
                     $time, got.bin_number, got.bin_value);
            error_count++;
         end else begin
            want = expected_rsp.pop_front();
            check_field("deposited", 48'(want.deposited), 48'(got.deposited));
            check_field("bin_number", 48'(want.bin_number), 48'(got.bin_number));
            check_field("bin_value", want.bin_value, got.bin_value);
            check_field("saturated", 48'(want.saturated), 48'(got.saturated));
         end
      end
   end

   // result side: backpressure
   always @(negedge clock) begin : rsp_drive
      if (hold_served != hold_requests) begin
         hold_left = LONG_HOLD_CYCLES;
         hold_served++;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 15) == 0) begin
         rsp_gap = $urandom_range(0, 14);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      foreach (bin_sums[i])
         bin_sums[i] = '0;
      cfg_periodic = 1'b0;
      for (int a = 0; a < 3; a++) begin
         cfg_min[a]   = 32'd0;
         cfg_scale[a] = w3dh_pkg::SCALE_RESET;
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // unit box at the origin, one cell = 1/16
      set_box(1'b0, 32'd0, 32'd0, 32'd0, w3dh_pkg::SCALE_RESET, w3dh_pkg::SCALE_RESET,
              w3dh_pkg::SCALE_RESET);
      pending_req.push_back(make_request(w3dh_pkg::REQ_DEPOSIT, 32'h8000, 32'h8000, 32'h8000,
                                         32'd1, 12'd0));
      pending_req.push_back(make_request(w3dh_pkg::REQ_DEPOSIT, 32'h8000, 32'h8000, 32'h8000,
                                         32'hFFFF_FFFF, 12'd0));
      pending_req.push_back(make_request(w3dh_pkg::REQ_DEPOSIT, 32'd1, 32'd1, 32'd1,
                                         32'hFFFF_FFFF, 12'd0));
      pending_req.push_back(make_request(w3dh_pkg::REQ_DEPOSIT, 32'hFFFF, 32'hFFFF, 32'hFFFF,
                                         32'd0, 12'd0));
      // on the lower face, on the upper face, below, far above, far below, on the upper z face
      pending_req.push_back(make_request(w3dh_pkg::REQ_DEPOSIT, 32'd0, 32'h8000, 32'h8000,
                                         32'd5, 12'd0));
      pending_req.push_back(make_request(w3dh_pkg::REQ_DEPOSIT, 32'h1_0000, 32'h8000,
                                         32'h8000, 32'd5, 12'd0));
      pending_req.push_back(make_request(w3dh_pkg::REQ_DEPOSIT, 32'hFFFF_FFFF, 32'h8000,
                                         32'h8000, 32'd5, 12'd0));
      pending_req.push_back(make_request(w3dh_pkg::REQ_DEPOSIT, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                         32'h7FFF_FFFF, 32'd5, 12'd0));
      pending_req.push_back(make_request(w3dh_pkg::REQ_DEPOSIT, 32'h8000_0000, 32'h8000_0000,
                                         32'h8000_0000, 32'd5, 12'd0));
      pending_req.push_back(make_request(w3dh_pkg::REQ_DEPOSIT, 32'h8000, 32'h8000,
                                         32'h1_0000, 32'd5, 12'd0));
      pending_req.push_back(make_request(w3dh_pkg::REQ_READ, 32'd0, 32'd0, 32'd0, 32'd0,
                                         12'h888));
      pending_req.push_back(make_request(w3dh_pkg::REQ_READ_CLEAR, 32'd0, 32'd0, 32'd0, 32'd0,
                                         12'h888));
      pending_req.push_back(make_request(w3dh_pkg::REQ_READ, 32'd0, 32'd0, 32'd0, 32'd0,
                                         12'h888));
      pending_req.push_back(make_request(w3dh_pkg::REQ_READ, 32'd0, 32'd0, 32'd0, 32'd0,
                                         12'h000));
      pending_req.push_back(make_request(w3dh_pkg::REQ_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                         32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF));
      pending_req.push_back(make_request(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                         32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF));
      pending_req.push_back(make_request(w3dh_pkg::REQ_READ_CLEAR, 32'd0, 32'd0, 32'd0, 32'd0,
                                         12'h000));
      pending_req.push_back(make_request(REQ_UNUSED, 32'd0, 32'd0, 32'd0, 32'd0, 12'd0));
      pending_req.push_back(make_request(w3dh_pkg::REQ_READ, $urandom, $urandom, $urandom,
                                         $urandom, 12'h555));
      pending_req.push_back(make_request(w3dh_pkg::REQ_DEPOSIT, 32'hFFFF, 32'hFFFF, 32'hFFFF,
                                         32'hFFFF_FFFF, 12'd0));
      queue_random_items(330);
      wait_drained();

      // periodic, extreme corners and scales (zero scale folds to cell 0)
      set_box(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, $urandom,
              32'hFFFF_FFFF, 32'd0, w3dh_pkg::SCALE_RESET);
      queue_random_items(300);
      wait_drained();

      // bounded random box; receiver stalls long while the queue is full
      set_box(1'b0, $urandom, $urandom, $urandom, $urandom_range(1 << 16, 1 << 26),
              $urandom_range(1 << 16, 1 << 26), $urandom_range(1 << 16, 1 << 26));
      queue_random_items(400);
      hold_requests++;
      wait_drained();

      set_box(1'b1, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      queue_random_items(350);
      wait_drained();

      // zero scale on x: every bounded deposit is dropped
      set_box(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, $urandom, 32'd0, 32'hFFFF_FFFF, $urandom);
      queue_random_items(40);
      wait_drained();

      // no idling from here on; hammer one bin with full-weight deposits
      idle_on = 1'b0;
      set_box(1'b0, 32'd0, 32'd0, 32'd0, w3dh_pkg::SCALE_RESET, w3dh_pkg::SCALE_RESET,
              w3dh_pkg::SCALE_RESET);
      for (int n = 0; n < SAT_DEPOSITS; n++)
         pending_req.push_back(make_request(w3dh_pkg::REQ_DEPOSIT, 32'h8000, 32'h8000,
                                            32'h8000, 32'hFFFF_FFFF, 12'd0));
      pending_req.push_back(make_request(w3dh_pkg::REQ_READ, 32'd0, 32'd0, 32'd0, 32'd0,
                                         12'h888));
      pending_req.push_back(make_request(w3dh_pkg::REQ_READ_CLEAR, 32'd0, 32'd0, 32'd0, 32'd0,
                                         12'h888));
      pending_req.push_back(make_request(w3dh_pkg::REQ_READ, 32'd0, 32'd0, 32'd0, 32'd0,
                                         12'h888));
      wait_drained();

      set_box(1'b0, $urandom, $urandom, $urandom, $urandom_range(1 << 16, 1 << 26),
              $urandom_range(1 << 16, 1 << 26), $urandom_range(1 << 16, 1 << 26));
      queue_random_items(400);
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_rsp.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
